// ----- rtl/core/pdos_pkg.sv -----
// ----------------------------------------------------------------------------
// pdos_pkg
// Shared types for the point distance order sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package pdos_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_FLUSH,
		ST_DRAIN
	} state_t;

	// broadcast to every sort cell
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/point_distance_order_sorter_top.sv -----
// ----------------------------------------------------------------------------
// point_distance_order_sorter_top
// Point table with nearest-first readout by squared distance.
//
//   channel  dir  tdata / tuser / tlast
//   s_*      in   tdata: pos_x, pos_y   tuser: cmd (0 add, 1 query)
//   m_*      out  tdata: point_index, distance_sq   tlast: last of query
//
// An add word completes in its accept cycle. A query over n stored points
// reads one point a cycle from the table RAM, fills the sort chain through
// the four-stage distance pipeline, then hands out n words at one per cycle
// while m_tready is high. A query on an empty table completes in its accept
// cycle. Reset clears the point count and the chain; table contents stay
// undefined. s_tready is low while a query is in progress; m_tready low
// holds the current output word.
// ----------------------------------------------------------------------------
`default_nettype none

module point_distance_order_sorter_top #(
	parameter int MAX_POINTS = 8,
	parameter int COORD_BITS = 16,
	localparam int IDX_W      = $clog2(MAX_POINTS),
	localparam int IN_TDATA_W = ((2*COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W      = IDX_W + 2*COORD_BITS + 1,
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // pos_x, pos_y
	input  wire logic                   s_tuser,   // cmd
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // point_index, distance_sq
	output logic                        m_tlast
);

	import pdos_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int KEY_W = 2*C + 1;

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [C-1:0]     ref_x_q, ref_y_q;
	logic             rd_v_q;
	logic [IDX_W-1:0] rd_idx_q;

	logic             in_acc, add_acc, qry_acc, wr_en, rd_en, out_acc, last_rd;
	logic [2*C-1:0]   rd_data;

	logic             dist_v, dist_busy;
	logic [IDX_W-1:0] dist_idx;
	logic [KEY_W-1:0] dist_key;

	cell_ctrl_t       ctrl;
	logic [MAX_POINTS-1:0] cell_v;
	logic [MAX_POINTS-1:0] cell_take;
	logic [KEY_W-1:0] cell_key [MAX_POINTS];
	logic [IDX_W-1:0] cell_idx [MAX_POINTS];

	assign in_acc  = s_tvalid && s_tready;
	assign add_acc = in_acc && !s_tuser;
	assign qry_acc = in_acc && s_tuser;
	assign wr_en   = add_acc && (count_q < CNT_W'(MAX_POINTS));
	assign out_acc = m_tvalid && m_tready;
	assign last_rd = (rd_cnt_q + CNT_W'(1)) == count_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (qry_acc && (count_q != '0)) begin
					state_nxt = ST_FILL;
				end
			end
			ST_FILL: begin
				if (last_rd) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!rd_v_q && !dist_busy) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_acc && m_tlast) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_FILL:  rd_en    = 1'b1;
			ST_FLUSH: ;
			ST_DRAIN: m_tvalid = cell_v[0];
			default:  ;
		endcase
	end

	assign ctrl.insert = dist_v;
	assign ctrl.shift  = out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_cnt_q <= '0;
			rd_v_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rd_v_q  <= rd_en;
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (qry_acc) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qry_acc) begin
			ref_x_q <= s_tdata[C-1:0];
			ref_y_q <= s_tdata[2*C-1:C];
		end
		rd_idx_q <= rd_cnt_q[IDX_W-1:0];
	end

	pdos_ram #(
		.WIDTH (2*C),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (s_tdata[2*C-1:0]),
		.re    (rd_en),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	pdos_dist #(
		.COORD_BITS (C),
		.IDX_W      (IDX_W)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (rd_v_q),
		.in_idx   (rd_idx_q),
		.pt_x     (rd_data[C-1:0]),
		.pt_y     (rd_data[2*C-1:C]),
		.ref_x    (ref_x_q),
		.ref_y    (ref_y_q),
		.out_v    (dist_v),
		.out_idx  (dist_idx),
		.out_dist (dist_key),
		.busy     (dist_busy)
	);

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		logic             p_take, p_v, n_v;
		logic [KEY_W-1:0] p_key, n_key;
		logic [IDX_W-1:0] p_idx, n_idx;

		if (i == 0) begin : g_head
			assign p_take = 1'b0;
			assign p_v    = 1'b0;
			assign p_key  = '0;
			assign p_idx  = '0;
		end else begin : g_mid
			assign p_take = cell_take[i-1];
			assign p_v    = cell_v[i-1];
			assign p_key  = cell_key[i-1];
			assign p_idx  = cell_idx[i-1];
		end

		if (i == MAX_POINTS - 1) begin : g_tail
			assign n_v   = 1'b0;
			assign n_key = '0;
			assign n_idx = '0;
		end else begin : g_body
			assign n_v   = cell_v[i+1];
			assign n_key = cell_key[i+1];
			assign n_idx = cell_idx[i+1];
		end

		pdos_cell #(
			.KEY_W (KEY_W),
			.IDX_W (IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_key   (dist_key),
			.new_idx   (dist_idx),
			.prev_take (p_take),
			.prev_v    (p_v),
			.prev_key  (p_key),
			.prev_idx  (p_idx),
			.next_v    (n_v),
			.next_key  (n_key),
			.next_idx  (n_idx),
			.take      (cell_take[i]),
			.valid     (cell_v[i]),
			.key       (cell_key[i]),
			.idx       (cell_idx[i])
		);
	end

	assign m_tdata = OUT_TDATA_W'({cell_key[0], cell_idx[0]});
	assign m_tlast = !cell_v[1];

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count above table size");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) && (state_nxt == ST_DRAIN)
		|=> $countones(cell_v) == count_q)
		else $error("sort chain does not hold every point");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) && cell_v[1] |-> cell_key[0] <= cell_key[1])
		else $error("chain head out of order");

	a_insert_window: assert property (@(posedge clk) disable iff (!arst_n)
		dist_v |-> (state_q == ST_FILL) || (state_q == ST_FLUSH))
		else $error("distance result outside a query");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while output pending");

endmodule

`default_nettype wire

// ----- rtl/core/pdos_ram.sv -----
// ----------------------------------------------------------------------------
// pdos_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pdos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/pdos_dist.sv -----
// ----------------------------------------------------------------------------
// pdos_dist
// Four-stage squared distance pipeline: difference, magnitude, square, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pdos_dist #(
	parameter int COORD_BITS = 16,
	parameter int IDX_W      = 3
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_v,
	input  wire logic [IDX_W-1:0]        in_idx,
	input  wire logic [COORD_BITS-1:0]   pt_x,
	input  wire logic [COORD_BITS-1:0]   pt_y,
	input  wire logic [COORD_BITS-1:0]   ref_x,
	input  wire logic [COORD_BITS-1:0]   ref_y,
	output logic                         out_v,
	output logic [IDX_W-1:0]             out_idx,
	output logic [2*COORD_BITS:0]        out_dist,
	output logic                         busy
);

	localparam int C = COORD_BITS;

	logic           v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [C:0]     dx_s1, dy_s1;
	logic [C-1:0]   ax_s2, ay_s2;
	logic [2*C-1:0] sqx_s3, sqy_s3;
	logic [2*C:0]   dist_s4;
	logic [C:0]     negx, negy;

	// magnitude of a C+1 bit difference always fits in C bits
	assign negx = dx_s1[C] ? (~dx_s1 + (C+1)'(1)) : dx_s1;
	assign negy = dy_s1[C] ? (~dy_s1 + (C+1)'(1)) : dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= in_idx;
		dx_s1   <= {pt_x[C-1], pt_x} - {ref_x[C-1], ref_x};
		dy_s1   <= {pt_y[C-1], pt_y} - {ref_y[C-1], ref_y};
		idx_s2  <= idx_s1;
		ax_s2   <= negx[C-1:0];
		ay_s2   <= negy[C-1:0];
		idx_s3  <= idx_s2;
		sqx_s3  <= ax_s2 * ax_s2;
		sqy_s3  <= ay_s2 * ay_s2;
		idx_s4  <= idx_s3;
		dist_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

	assign out_v    = v_s4;
	assign out_idx  = idx_s4;
	assign out_dist = dist_s4;
	assign busy     = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

`default_nettype wire

// ----- rtl/core/pdos_cell.sv -----
// ----------------------------------------------------------------------------
// pdos_cell
// One slot of the insertion sort chain: holds a key and an index, takes the
// new entry or its left neighbor on insert, its right neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module pdos_cell #(
	parameter int KEY_W = 33,
	parameter int IDX_W = 3
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  pdos_pkg::cell_ctrl_t        ctrl,
	input  wire logic [KEY_W-1:0]       new_key,
	input  wire logic [IDX_W-1:0]       new_idx,
	input  wire logic                   prev_take,
	input  wire logic                   prev_v,
	input  wire logic [KEY_W-1:0]       prev_key,
	input  wire logic [IDX_W-1:0]       prev_idx,
	input  wire logic                   next_v,
	input  wire logic [KEY_W-1:0]       next_key,
	input  wire logic [IDX_W-1:0]       next_idx,
	output logic                        take,
	output logic                        valid,
	output logic [KEY_W-1:0]            key,
	output logic [IDX_W-1:0]            idx
);

	import pdos_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;

	// strict compare keeps equal keys in arrival (index) order
	assign take = !valid_q || (key_q > new_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (prev_take) begin
				valid_q <= prev_v;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end else if (ctrl.shift) begin
			valid_q <= next_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (prev_take) begin
				key_q <= prev_key;
				idx_q <= prev_idx;
			end else if (take) begin
				key_q <= new_key;
				idx_q <= new_idx;
			end
		end else if (ctrl.shift) begin
			key_q <= next_key;
			idx_q <= next_idx;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign idx   = idx_q;

endmodule

`default_nettype wire

// ----- verif/tb_point_distance_order_sorter_top.sv -----
// ----------------------------------------------------------------------------
// tb_point_distance_order_sorter_top
// Self-checking bench for the point distance order sorter.
//
// Fills the point table step by step with queries in between, then keeps
// issuing random queries against the full table. Adds that the full table
// drops are mixed in. Each query's ordering, computed here (exact squared
// distance, ties to the lower index) or given in a typed row, is compared
// word by word with m_*. Both stream sides idle in random bursts. The final
// stretch runs without idling.
// ----------------------------------------------------------------------------

module tb_point_distance_order_sorter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit CMD_ADD   = 1'b0;
	localparam bit CMD_QUERY = 1'b1;
	localparam int TABLE_DEPTH = 8;
	localparam int RAND_QUERIES = 95;
	localparam int CALM_QUERIES = 30;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [2:0]  idx;
		logic [32:0] dist_sq;
		logic        last;
	} ranked_t;

	// directed rows; typed = expectation given in the row itself
	typedef struct packed {
		bit                 cmd;
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit                 typed;
		bit                 t_one;   // typed row yields one word (else none)
		logic [2:0]         t_idx;
		logic [32:0]        t_dist;
	} stim_row_t;

	localparam int DIR_ROWS = 23;
	localparam logic [32:0] DIST_FAR = 33'd8589672450;

	stim_row_t dir_tab [DIR_ROWS] = '{
		// empty table: nothing comes back
		'{CMD_QUERY, 16'sd0,      16'sd0,      1'b1, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, -16'sd32768, 16'sd32767,  1'b1, 1'b0, 3'd0, 33'd0},
		'{CMD_ADD,   -16'sd32768, -16'sd32768, 1'b0, 1'b0, 3'd0, 33'd0},
		// opposite corners: largest distance
		'{CMD_QUERY, 16'sd32767,  16'sd32767,  1'b1, 1'b1, 3'd0, DIST_FAR},
		'{CMD_QUERY, -16'sd32768, -16'sd32768, 1'b1, 1'b1, 3'd0, 33'd0},
		'{CMD_ADD,   16'sd32767,  16'sd32767,  1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, 16'sd0,      16'sd0,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_ADD,   16'sd0,      16'sd0,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_ADD,   16'sd100,    -16'sd100,   1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, 16'sd0,      16'sd0,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_ADD,   -16'sd100,   16'sd100,    1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, 16'sd0,      16'sd0,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_ADD,   16'sd1,      16'sd0,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_ADD,   16'sd0,      16'sd1,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, 16'sd0,      16'sd0,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_ADD,   -16'sd1,     -16'sd1,     1'b0, 1'b0, 3'd0, 33'd0},
		// table full: these adds are dropped
		'{CMD_ADD,   16'sd5,      16'sd5,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_ADD,   16'sd32767,  -16'sd32768, 1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, 16'sd0,      16'sd0,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, 16'sd32767,  -16'sd32768, 1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, -16'sd32768, 16'sd32767,  1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, 16'sd1,      16'sd1,      1'b0, 1'b0, 3'd0, 33'd0},
		'{CMD_QUERY, 16'sd100,    16'sd100,    1'b0, 1'b0, 3'd0, 33'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	// shadow of the point table
	logic signed [15:0] pt_x [TABLE_DEPTH];
	logic signed [15:0] pt_y [TABLE_DEPTH];
	int                 pt_cnt = 0;

	ranked_t order_q [$];
	int      err_cnt = 0;
	int      cycle_cnt = 0;
	int      stall_left = 0;
	bit      idling = 1'b1;
	bit      calm = 1'b0;

	point_distance_order_sorter_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void note_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("mismatch @%0d: %s", cycle_cnt, msg);
	endfunction

	// nearest-first ordering of the stored points around (rx, ry)
	function automatic void rank_by_distance(input logic signed [15:0] rx,
			input logic signed [15:0] ry);
		longint  d [TABLE_DEPTH];
		int      ord [TABLE_DEPTH];
		longint  dx, dy;
		int      k, j;
		ranked_t r;
		for (int i = 0; i < pt_cnt; i++) begin
			dx = longint'(pt_x[i]) - longint'(rx);
			dy = longint'(pt_y[i]) - longint'(ry);
			d[i] = dx * dx + dy * dy;
			ord[i] = i;
		end
		// strict compare keeps equal distances in index order
		for (int i = 1; i < pt_cnt; i++) begin
			k = ord[i];
			j = i;
			while (j > 0 && d[ord[j-1]] > d[k]) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = k;
		end
		for (int i = 0; i < pt_cnt; i++) begin
			r.idx     = 3'(ord[i]);
			r.dist_sq = 33'(d[ord[i]]);
			r.last    = (i == pt_cnt - 1);
			order_q.push_back(r);
		end
	endfunction

	// drive one word, update the shadow table at acceptance
	task automatic send_word(input bit cmd, input logic signed [15:0] x,
			input logic signed [15:0] y, input bit predict);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {y, x};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_ADD) begin
			if (pt_cnt < TABLE_DEPTH) begin
				pt_x[pt_cnt] = x;
				pt_y[pt_cnt] = y;
				pt_cnt++;
			end
		end else if (predict) begin
			rank_by_distance(x, y);
		end
		gap = 0;
		if (!calm && idling && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] corner_coord();
		case ($urandom_range(0, 4))
			0: return -16'sd32768;
			1: return -16'sd1;
			2: return 16'sd0;
			3: return 16'sd1;
			default: return 16'sd32767;
		endcase
	endfunction

	// result side: random stalls and checking
	always @(posedge clk) begin
		ranked_t e;
		if ($urandom_range(0, 63) == 0)
			idling <= !idling;
		if (!arst_n || calm || !idling) begin
			m_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end

		if (arst_n && m_tvalid && m_tready) begin
			if (order_q.size() == 0) begin
				note_error($sformatf("unexpected word idx=%0d dist=%0d last=%0b",
					m_tdata[2:0], m_tdata[35:3], m_tlast));
			end else begin
				e = order_q.pop_front();
				if (m_tdata[2:0] !== e.idx || m_tdata[35:3] !== e.dist_sq
						|| m_tlast !== e.last)
					note_error($sformatf(
						"exp idx=%0d dist=%0d last=%0b, got idx=%0d dist=%0d last=%0b",
						e.idx, e.dist_sq, e.last, m_tdata[2:0], m_tdata[35:3], m_tlast));
			end
		end
	end

	initial begin
		ranked_t            r;
		int                 n_query;
		int                 pick;
		logic signed [15:0] qx, qy;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].typed && dir_tab[i].t_one) begin
				r.idx     = dir_tab[i].t_idx;
				r.dist_sq = dir_tab[i].t_dist;
				r.last    = 1'b1;
				order_q.push_back(r);
			end
			send_word(dir_tab[i].cmd, dir_tab[i].x, dir_tab[i].y, !dir_tab[i].typed);
		end

		// full table from here on; adds are dropped and not counted
		n_query = 0;
		while (n_query < RAND_QUERIES) begin
			calm = (n_query >= RAND_QUERIES - CALM_QUERIES);
			if ($urandom_range(0, 3) == 0) begin
				send_word(CMD_ADD, 16'($urandom), 16'($urandom), 1'b1);
			end else begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: begin
						qx = 16'($urandom);
						qy = 16'($urandom);
					end
					1: begin
						qx = 16'($urandom_range(0, 400)) - 16'sd200;
						qy = 16'($urandom_range(0, 400)) - 16'sd200;
					end
					2: begin
						pick = $urandom_range(0, pt_cnt - 1);
						qx = pt_x[pick];
						qy = pt_y[pick];
					end
					default: begin
						qx = corner_coord();
						qy = corner_coord();
					end
				endcase
				send_word(CMD_QUERY, qx, qy, 1'b1);
				n_query++;
			end
		end
		s_tvalid <= 1'b0;

		while (order_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
